FILE: design/sha256_byte_stream_hasher_core_defines.svh
// Assertion macros for the hasher checker.
`ifndef SHA256_BYTE_STREAM_HASHER_CORE_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SHABS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SHABS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/shabs_pkg.sv
package shabs_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0][31:0] vars_t;

  localparam logic [1:0] REQ_ABSORB        = 2'd0;
  localparam logic [1:0] REQ_ABSORB_FINISH = 2'd1;
  localparam logic [1:0] REQ_FINISH        = 2'd2;
  localparam logic [1:0] REQ_UNUSED        = 2'd3;

  localparam logic [7:0] PAD_MARK      = 8'h80;
  localparam logic [5:0] LEN_FIELD_POS = 6'd56;

  localparam vars_t INITIAL_HASH = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t round_k(input logic [5:0] idx);
    case (idx)
      6'd0:  round_k = 32'h428a2f98;
      6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;
      6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;
      6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;
      6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;
      6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;
      6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;
      6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;
      6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;
      6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;
      6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;
      6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;
      6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;
      6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;
      6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;
      6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;
      6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;
      6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;
      6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;
      6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;
      6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;
      6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;
      6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;
      6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;
      6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;
      6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;
      6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;
      6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;
      6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;
      6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;
      6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;
      6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;
      6'd63: round_k = 32'hc67178f2;
      default: round_k = 32'h0;
    endcase
  endfunction

endpackage

FILE: design/shabs_if.sv
interface shabs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] data_byte;

  modport source (output valid, output req_type, output data_byte, input ready);
  modport sink (input valid, input req_type, input data_byte, output ready);
endinterface

interface shabs_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word0;
  logic [63:0] digest_word1;
  logic [63:0] digest_word2;
  logic [63:0] digest_word3;

  modport source (
    output valid, output digest_word0, output digest_word1,
    output digest_word2, output digest_word3, input ready
  );
  modport sink (
    input valid, input digest_word0, input digest_word1,
    input digest_word2, input digest_word3, output ready
  );
endinterface

FILE: design/shabs_round_unit.sv
module shabs_round_unit (
  input  shabs_pkg::vars_t vars_in,
  input  shabs_pkg::word_t w_in,
  input  shabs_pkg::word_t k_in,
  input  shabs_pkg::word_t sched_w0,
  input  shabs_pkg::word_t sched_w1,
  input  shabs_pkg::word_t sched_w9,
  input  shabs_pkg::word_t sched_w14,
  output shabs_pkg::vars_t vars_out,
  output shabs_pkg::word_t sched_new
);
  import shabs_pkg::*;

  word_t ch;
  word_t maj;
  word_t t1;
  word_t t2;

  assign ch  = (vars_in[4] & vars_in[5]) ^ (~vars_in[4] & vars_in[6]);
  assign maj = (vars_in[0] & vars_in[1]) ^ (vars_in[0] & vars_in[2]) ^
               (vars_in[1] & vars_in[2]);
  assign t1  = vars_in[7] + big_sigma1(vars_in[4]) + ch + k_in + w_in;
  assign t2  = big_sigma0(vars_in[0]) + maj;

  always_comb begin
    vars_out[7] = vars_in[6];
    vars_out[6] = vars_in[5];
    vars_out[5] = vars_in[4];
    vars_out[4] = vars_in[3] + t1;
    vars_out[3] = vars_in[2];
    vars_out[2] = vars_in[1];
    vars_out[1] = vars_in[0];
    vars_out[0] = t1 + t2;
  end

  assign sched_new = small_sigma1(sched_w14) + sched_w9 + small_sigma0(sched_w1) + sched_w0;

endmodule

FILE: design/sha256_byte_stream_hasher_core.sv
// SHA-256 hasher over a byte stream.
// Input channel in_ch carries one request per handshake: req_type 0 absorbs
// data_byte, 1 absorbs data_byte and finishes the message, 2 finishes without
// a byte, and 3 is taken and ignored. Output channel out_ch carries the digest
// as four big-endian 64-bit words, one result per finishing request.
// The 64th byte of a block starts a compression: a load, 64 rounds on the
// single round unit and the chaining update; the block is not ready meanwhile.
// Finishing shifts in the padding through the block buffer, one byte per cycle
// while no compression runs, and runs one or two compressions, depending on
// the bytes already buffered.
// The digest sits in an output register; the core takes new requests while it
// waits. If a second digest is ready before the first is taken, the core holds
// in its emit step until out_ch.ready frees the output register.
// Reset, synchronous and active low, restores the initial hash values and
// clears the byte and block counts and the output valid flag.
module sha256_byte_stream_hasher_core (
  input logic       clk,
  input logic       rst_n,
  shabs_in_if.sink  in_ch,
  shabs_out_if.source out_ch
);
  import shabs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MARK, ST_ZERO, ST_LEN, ST_LOAD, ST_ROUND, ST_ADD, ST_EMIT
  } state_t;

  state_t       state_r, state_nxt;
  state_t       ret_r, ret_nxt;
  logic [5:0]   fill_r, fill_nxt;
  logic [54:0]  blocks_r, blocks_nxt;
  vars_t        chain_r, chain_nxt;
  logic         out_valid_r, out_valid_nxt;

  logic [511:0] buf_r, buf_nxt;
  logic [63:0]  total_r, total_nxt;
  logic [2:0]   len_cnt_r, len_cnt_nxt;
  logic [5:0]   rnd_r, rnd_nxt;
  vars_t        work_r, work_nxt;
  vars_t        digest_r, digest_nxt;

  logic         shift_en;
  logic [7:0]   shift_byte;
  vars_t        round_vars;
  word_t        sched_new;

  shabs_round_unit u_round (
    .vars_in   (work_r),
    .w_in      (buf_r[511:480]),
    .k_in      (round_k(rnd_r)),
    .sched_w0  (buf_r[511:480]),
    .sched_w1  (buf_r[479:448]),
    .sched_w9  (buf_r[223:192]),
    .sched_w14 (buf_r[63:32]),
    .vars_out  (round_vars),
    .sched_new (sched_new)
  );

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.digest_word0 = {digest_r[0], digest_r[1]};
  assign out_ch.digest_word1 = {digest_r[2], digest_r[3]};
  assign out_ch.digest_word2 = {digest_r[4], digest_r[5]};
  assign out_ch.digest_word3 = {digest_r[6], digest_r[7]};

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    fill_nxt      = fill_r;
    blocks_nxt    = blocks_r;
    chain_nxt     = chain_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    buf_nxt       = buf_r;
    total_nxt     = total_r;
    len_cnt_nxt   = len_cnt_r;
    rnd_nxt       = rnd_r;
    work_nxt      = work_r;
    digest_nxt    = digest_r;
    shift_en      = 1'b0;
    shift_byte    = 8'h00;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          case (in_ch.req_type)
            REQ_ABSORB: begin
              shift_en   = 1'b1;
              shift_byte = in_ch.data_byte;
              if (fill_r == 6'd63) begin
                state_nxt = ST_LOAD;
                ret_nxt   = ST_IDLE;
              end
            end
            REQ_ABSORB_FINISH: begin
              shift_en   = 1'b1;
              shift_byte = in_ch.data_byte;
              if (fill_r == 6'd63) begin
                state_nxt = ST_LOAD;
                ret_nxt   = ST_MARK;
              end else begin
                state_nxt = ST_MARK;
              end
            end
            REQ_FINISH: begin
              state_nxt = ST_MARK;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_MARK: begin
        // Completed blocks are whole multiples of 512 bits.
        total_nxt  = {blocks_r, fill_r, 3'b000};
        shift_en   = 1'b1;
        shift_byte = PAD_MARK;
        if (fill_r == 6'd63) begin
          state_nxt = ST_LOAD;
          ret_nxt   = ST_ZERO;
        end else begin
          state_nxt = ST_ZERO;
        end
      end
      ST_ZERO: begin
        if (fill_r == LEN_FIELD_POS) begin
          state_nxt   = ST_LEN;
          len_cnt_nxt = 3'd0;
        end else begin
          shift_en = 1'b1;
          if (fill_r == 6'd63) begin
            state_nxt = ST_LOAD;
            ret_nxt   = ST_ZERO;
          end
        end
      end
      ST_LEN: begin
        shift_en    = 1'b1;
        shift_byte  = total_r[63:56];
        total_nxt   = {total_r[55:0], 8'h00};
        len_cnt_nxt = len_cnt_r + 3'd1;
        if (len_cnt_r == 3'd7) begin
          state_nxt = ST_LOAD;
          ret_nxt   = ST_EMIT;
        end
      end
      ST_LOAD: begin
        work_nxt  = chain_r;
        rnd_nxt   = 6'd0;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        work_nxt = round_vars;
        buf_nxt  = {buf_r[479:0], sched_new};
        rnd_nxt  = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        for (int i = 0; i < 8; i++) begin
          chain_nxt[i] = chain_r[i] + work_r[i];
        end
        state_nxt = ret_r;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          digest_nxt    = chain_r;
          out_valid_nxt = 1'b1;
          chain_nxt     = INITIAL_HASH;
          fill_nxt      = 6'd0;
          blocks_nxt    = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (shift_en) begin
      buf_nxt  = {buf_r[503:0], shift_byte};
      fill_nxt = fill_r + 6'd1;
      if (fill_r == 6'd63) begin
        blocks_nxt = blocks_r + 55'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      fill_r      <= 6'd0;
      blocks_r    <= '0;
      chain_r     <= INITIAL_HASH;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      fill_r      <= fill_nxt;
      blocks_r    <= blocks_nxt;
      chain_r     <= chain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r     <= buf_nxt;
    total_r   <= total_nxt;
    len_cnt_r <= len_cnt_nxt;
    rnd_r     <= rnd_nxt;
    work_r    <= work_nxt;
    digest_r  <= digest_nxt;
  end

endmodule

FILE: design/shabs_checker.sv
`include "sha256_byte_stream_hasher_core_defines.svh"

module shabs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_req_type,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_digest_word0
);
  import shabs_pkg::*;

  logic in_acc;

  assign in_acc = in_valid && in_ready;

  // A finishing request always starts padding, which blocks new requests.
  `SHABS_ASSERT_NEXT(a_finish_blocks, in_acc && (in_req_type == REQ_ABSORB_FINISH || in_req_type == REQ_FINISH), !in_ready, "finishing request did not start padding")
  // A plain byte can never make a digest appear in the next cycle.
  `SHABS_ASSERT_NEXT(a_absorb_no_digest, in_acc && in_req_type == REQ_ABSORB, !$rose(out_valid), "digest appeared right after a plain byte")
  // The unused request code leaves the core ready.
  `SHABS_ASSERT_NEXT(a_unused_code_idle, in_acc && in_req_type == REQ_UNUSED, in_ready, "unused request code changed state")
  `SHABS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "digest dropped before it was taken")
  `SHABS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_digest_word0), "digest changed while stalled")

endmodule

bind sha256_byte_stream_hasher_core shabs_checker u_shabs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_req_type      (in_ch.req_type),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_digest_word0 (out_ch.digest_word0)
);
